>>> rtl/u8pw_pkg.sv
package u8pw_pkg;

  localparam int REG_W       = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int ERR_W       = 4;
  localparam int ACC_W       = 21;
  localparam int COUNT_BITS_DEF = 10;

  localparam logic [REG_W-1:0] MAX_BYTES_RST = 10'd256;
  localparam logic [REG_W-1:0] MIN_CHARS_RST = 10'd8;
  localparam logic [REG_W-1:0] MAX_CHARS_RST = 10'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_BYTES = 2'd0,
    CFG_MIN_CHARS = 2'd1,
    CFG_MAX_CHARS = 2'd2
  } cfg_idx_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE      = 4'd0,
    ERR_TOO_LONG  = 4'd1,
    ERR_CONTROL   = 4'd2,
    ERR_BAD_LEAD  = 4'd3,
    ERR_TRUNCATED = 4'd4,
    ERR_BAD_CONT  = 4'd5,
    ERR_BAD_CP    = 4'd6,
    ERR_FEW_CHARS = 4'd7,
    ERR_MANY_CHARS = 4'd8
  } err_t;

  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_DEL   = 8'h7F;

  localparam logic [ACC_W-1:0] CP_C1_LO    = 21'h000080;
  localparam logic [ACC_W-1:0] CP_C1_HI    = 21'h00009F;
  localparam logic [ACC_W-1:0] CP_MIN_3B   = 21'h000800;
  localparam logic [ACC_W-1:0] CP_SURR_LO  = 21'h00D800;
  localparam logic [ACC_W-1:0] CP_SURR_HI  = 21'h00DFFF;
  localparam logic [ACC_W-1:0] CP_MIN_4B   = 21'h010000;
  localparam logic [ACC_W-1:0] CP_MAX      = 21'h10FFFF;

endpackage

>>> rtl/utf8_password_checker.sv
// UTF-8 password checker.
// Input channel: one password byte per transfer (in_data_byte, in_has_byte,
// in_last). An item with in_has_byte low carries no byte; with in_last high it
// closes an open password. Each password ends with an item flagged in_last,
// which produces exactly one result transfer on the out_ channel: pass/fail,
// error code and character count. Other items produce nothing.
// Throughput: one item per cycle while in_stall is low. The result of a last
// item passes through the input register and then the result register; the
// decode step between them is one byte of UTF-8 state update.
// A stalled result is held in the result register while a following item
// still enters the input register; only when that item is also a last item
// and the result register cannot drain does in_stall rise.
// Configuration (max_bytes, min_chars, max_chars) is written through cfg_we,
// cfg_index and cfg_data; the user must write it only while no password is in
// flight, as the block does not enforce this. Unknown indexes are ignored.
// Reset (rst_n low, synchronous) empties both registers, clears the decode
// state and restores the limits to 256 bytes, 8 and 64 characters.
module utf8_password_checker
  import u8pw_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_has_byte,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_valid_res,
  output logic [ERR_W-1:0]     out_error_code,
  output logic [REG_W-1:0]     out_char_count,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  localparam int BC_W  = COUNT_BITS + 1;
  localparam int CMP_W = (BC_W > REG_W) ? BC_W : REG_W;
  localparam logic [BC_W-1:0]       BYTE_TOP = BC_W'(1) << COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CHAR_TOP = '1;
  localparam logic [CMP_W-1:0]      REG_MAX  = CMP_W'({REG_W{1'b1}});

  logic [REG_W-1:0] max_bytes_r, min_chars_r, max_chars_r;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_has_r, s1_last_r;

  logic [BC_W-1:0]       byte_cnt_r, byte_cnt_nxt;
  logic [COUNT_BITS-1:0] char_cnt_r, char_cnt_nxt;
  logic [1:0]            pend_r, pend_nxt;
  logic [1:0]            kind_r, kind_nxt;
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  err_t                  err_r, err_nxt;
  logic                  bad_cont_r, bad_cont_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       res_ok_r;
  err_t       res_code_r, res_code;
  logic [REG_W-1:0] res_cnt_r, res_cnt;

  logic in_xfer, slot_free, s1_go, s1_res;
  logic [1:0] pend_dec;
  logic [ACC_W-1:0] cp;
  logic cp_bad;
  logic [CMP_W-1:0] bc_ext, cc_ext;

  assign slot_free = !out_valid_r || !out_stall;
  assign s1_go     = s1_valid_r && (!s1_last_r || slot_free);
  assign s1_res    = s1_go && s1_last_r;
  assign in_stall  = s1_valid_r && !s1_go;
  assign in_xfer   = in_valid && !in_stall;

  always_comb begin
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  // one byte of decode
  always_comb begin
    byte_cnt_nxt = byte_cnt_r;
    char_cnt_nxt = char_cnt_r;
    pend_nxt     = pend_r;
    kind_nxt     = kind_r;
    acc_nxt      = acc_r;
    err_nxt      = err_r;
    bad_cont_nxt = bad_cont_r;
    pend_dec     = pend_r - 2'd1;
    cp           = {acc_r[ACC_W-7:0], s1_byte_r[5:0]};
    cp_bad       = (cp >= CP_C1_LO) && (cp <= CP_C1_HI);
    if (kind_r == 2'd2 && (cp < CP_MIN_3B || (cp >= CP_SURR_LO && cp <= CP_SURR_HI))) begin
      cp_bad = 1'b1;
    end
    if (kind_r == 2'd3 && (cp < CP_MIN_4B || cp > CP_MAX)) begin
      cp_bad = 1'b1;
    end

    if (s1_has_r) begin
      if (byte_cnt_r < BYTE_TOP) begin
        byte_cnt_nxt = byte_cnt_r + BC_W'(1);
      end
      if (err_r == ERR_NONE) begin
        if (pend_r == 2'd0) begin
          bad_cont_nxt = 1'b0;
          if (!s1_byte_r[7]) begin
            if (s1_byte_r < ASCII_SPACE || s1_byte_r == ASCII_DEL) begin
              err_nxt = ERR_CONTROL;
            end else if (char_cnt_r < CHAR_TOP) begin
              char_cnt_nxt = char_cnt_r + COUNT_BITS'(1);
            end
          end else if (s1_byte_r inside {[8'hC2:8'hDF]}) begin
            pend_nxt = 2'd1;
            kind_nxt = 2'd1;
            acc_nxt  = ACC_W'(s1_byte_r[4:0]);
          end else if (s1_byte_r inside {[8'hE0:8'hEF]}) begin
            pend_nxt = 2'd2;
            kind_nxt = 2'd2;
            acc_nxt  = ACC_W'(s1_byte_r[3:0]);
          end else if (s1_byte_r inside {[8'hF0:8'hF4]}) begin
            pend_nxt = 2'd3;
            kind_nxt = 2'd3;
            acc_nxt  = ACC_W'(s1_byte_r[2:0]);
          end else begin
            err_nxt = ERR_BAD_LEAD;
          end
        end else begin
          acc_nxt      = cp;
          pend_nxt     = pend_dec;
          bad_cont_nxt = bad_cont_r || (s1_byte_r[7:6] != 2'b10);
          if (pend_dec == 2'd0) begin
            if (bad_cont_nxt) begin
              err_nxt = ERR_BAD_CONT;
            end else if (cp_bad) begin
              err_nxt = ERR_BAD_CP;
            end else if (char_cnt_r < CHAR_TOP) begin
              char_cnt_nxt = char_cnt_r + COUNT_BITS'(1);
            end
            kind_nxt     = 2'd0;
            bad_cont_nxt = 1'b0;
          end
        end
      end
    end
  end

  // verdict on the state after the closing item
  always_comb begin
    bc_ext = CMP_W'(byte_cnt_nxt);
    cc_ext = CMP_W'(char_cnt_nxt);
    if (bc_ext > CMP_W'(max_bytes_r)) begin
      res_code = ERR_TOO_LONG;
    end else if (err_nxt != ERR_NONE) begin
      res_code = err_nxt;
    end else if (pend_nxt != 2'd0) begin
      res_code = ERR_TRUNCATED;
    end else if (cc_ext < CMP_W'(min_chars_r)) begin
      res_code = ERR_FEW_CHARS;
    end else if (cc_ext > CMP_W'(max_chars_r)) begin
      res_code = ERR_MANY_CHARS;
    end else begin
      res_code = ERR_NONE;
    end
    res_cnt = (cc_ext > REG_MAX) ? REG_W'(REG_MAX) : REG_W'(cc_ext);
  end

  always_comb begin
    if (s1_res) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= MAX_BYTES_RST;
      min_chars_r <= MIN_CHARS_RST;
      max_chars_r <= MAX_CHARS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_BYTES: max_bytes_r <= cfg_data;
        CFG_MIN_CHARS: min_chars_r <= cfg_data;
        CFG_MAX_CHARS: max_chars_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      byte_cnt_r  <= '0;
      char_cnt_r  <= '0;
      pend_r      <= '0;
      kind_r      <= '0;
      acc_r       <= '0;
      err_r       <= ERR_NONE;
      bad_cont_r  <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_res) begin
        byte_cnt_r <= '0;
        char_cnt_r <= '0;
        pend_r     <= '0;
        kind_r     <= '0;
        acc_r      <= '0;
        err_r      <= ERR_NONE;
        bad_cont_r <= 1'b0;
      end else if (s1_go) begin
        byte_cnt_r <= byte_cnt_nxt;
        char_cnt_r <= char_cnt_nxt;
        pend_r     <= pend_nxt;
        kind_r     <= kind_nxt;
        acc_r      <= acc_nxt;
        err_r      <= err_nxt;
        bad_cont_r <= bad_cont_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_data_byte;
      s1_has_r  <= in_has_byte;
      s1_last_r <= in_last;
    end
    if (s1_res) begin
      res_ok_r   <= (res_code == ERR_NONE);
      res_code_r <= res_code;
      res_cnt_r  <= res_cnt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_valid_res  = res_ok_r;
  assign out_error_code = res_code_r;
  assign out_char_count = res_cnt_r;

endmodule

>>> sim/utf8_password_checker_tb.sv
`timescale 1ns / 1ps

module utf8_password_checker_tb;
  import u8pw_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 150;
  localparam int LATENCY_PAD  = 6;
  localparam logic [10:0] BYTE_TOP = 11'd1024;
  localparam logic [9:0]  CHAR_TOP = 10'd1023;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int STALL_NONE     = 0;
  localparam int STALL_LIGHT    = 1;
  localparam int STALL_HEAVY    = 2;
  localparam int STALL_PERIODIC = 3;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic       ok;
    err_t       code;
    logic [9:0] chars;
  } verdict_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_data_byte = 8'h00;
  logic                 in_has_byte = 1'b0;
  logic                 in_last = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_valid_res;
  logic [ERR_W-1:0]     out_error_code;
  logic [REG_W-1:0]     out_char_count;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MAX_BYTES;
  logic [REG_W-1:0]     cfg_data = '0;

  // limits as the block should hold them
  logic [9:0] lim_max_bytes = MAX_BYTES_RST;
  logic [9:0] lim_min_chars = MIN_CHARS_RST;
  logic [9:0] lim_max_chars = MAX_CHARS_RST;

  // running decode state of the open password
  logic [10:0] seen_bytes = '0;
  logic [9:0]  good_chars = '0;
  logic [1:0]  cont_left = '0;
  logic [1:0]  seq_len = '0;
  logic [20:0] cp_acc = '0;
  err_t        err_first = ERR_NONE;
  logic        cont_broken = 1'b0;

  verdict_t pending_verdicts[$];
  verdict_t want;
  byte_q_t  pw_buf;

  int fail_count = 0;
  int verdicts_checked = 0;
  int n_passwords = 0;
  int n_bytes_sent = 0;
  int n_empty = 0;
  int stalled_offers = 0;
  int limit_writes = 0;
  int cycle_count = 0;

  int burst_left = 0;
  int gap_max = 0;
  int stall_mode = STALL_NONE;
  int stall_phase = 0;
  int hold_ticket = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int held_cycles = 0;

  utf8_password_checker dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_has_byte    (in_has_byte),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_valid_res  (out_valid_res),
    .out_error_code (out_error_code),
    .out_char_count (out_char_count),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10)
      $display("%s", msg);
  endtask

  // Decode one accepted item; a last item closes the password and queues its verdict.
  task automatic apply_password_item(input logic [7:0] b, input logic has, input logic fin);
    logic     bad_cp;
    verdict_t v;
    if (has) begin
      n_bytes_sent++;
      if (seen_bytes != BYTE_TOP)
        seen_bytes++;
      if (err_first == ERR_NONE) begin
        if (cont_left == 2'd0) begin
          cont_broken = 1'b0;
          if (b < 8'h80) begin
            if (b < ASCII_SPACE || b == ASCII_DEL)
              err_first = ERR_CONTROL;
            else if (good_chars != CHAR_TOP)
              good_chars++;
          end else if (b >= 8'hC2 && b <= 8'hDF) begin
            cont_left = 2'd1; seq_len = 2'd1; cp_acc = 21'(b & 8'h1F);
          end else if (b >= 8'hE0 && b <= 8'hEF) begin
            cont_left = 2'd2; seq_len = 2'd2; cp_acc = 21'(b & 8'h0F);
          end else if (b >= 8'hF0 && b <= 8'hF4) begin
            cont_left = 2'd3; seq_len = 2'd3; cp_acc = 21'(b & 8'h07);
          end else begin
            err_first = ERR_BAD_LEAD;
          end
        end else begin
          // a non-continuation byte still takes its slot; flagged once the sequence is full
          if (b[7:6] != 2'b10)
            cont_broken = 1'b1;
          cp_acc = {cp_acc[14:0], b[5:0]};
          cont_left--;
          if (cont_left == 2'd0) begin
            bad_cp = cp_acc >= CP_C1_LO && cp_acc <= CP_C1_HI;
            if (seq_len == 2'd2 &&
                (cp_acc < CP_MIN_3B || (cp_acc >= CP_SURR_LO && cp_acc <= CP_SURR_HI)))
              bad_cp = 1'b1;
            if (seq_len == 2'd3 && (cp_acc < CP_MIN_4B || cp_acc > CP_MAX))
              bad_cp = 1'b1;
            if (cont_broken)
              err_first = ERR_BAD_CONT;
            else if (bad_cp)
              err_first = ERR_BAD_CP;
            else if (good_chars != CHAR_TOP)
              good_chars++;
            seq_len = 2'd0;
            cont_broken = 1'b0;
          end
        end
      end
    end else begin
      n_empty++;
    end
    if (fin) begin
      if (seen_bytes > lim_max_bytes)
        v.code = ERR_TOO_LONG;
      else if (err_first != ERR_NONE)
        v.code = err_first;
      else if (cont_left != 2'd0)
        v.code = ERR_TRUNCATED;
      else if (good_chars < lim_min_chars)
        v.code = ERR_FEW_CHARS;
      else if (good_chars > lim_max_chars)
        v.code = ERR_MANY_CHARS;
      else
        v.code = ERR_NONE;
      v.ok = v.code == ERR_NONE;
      v.chars = good_chars;
      pending_verdicts.push_back(v);
      n_passwords++;
      seen_bytes = '0; good_chars = '0; cont_left = '0; seq_len = '0;
      cp_acc = '0; err_first = ERR_NONE; cont_broken = 1'b0;
    end
  endtask

  // input side: every transfer goes through the decode model
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      apply_password_item(in_data_byte, in_has_byte, in_last);
    if (rst_n && in_valid && in_stall)
      stalled_offers++;
  end

  // result side
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        note_failure($sformatf("unexpected verdict: ok=%0b code=%0d chars=%0d",
                               out_valid_res, out_error_code, out_char_count));
      end else begin
        want = pending_verdicts.pop_front();
        verdicts_checked++;
        if (out_valid_res !== want.ok || out_error_code !== want.code ||
            out_char_count !== want.chars)
          note_failure($sformatf(
            "verdict %0d: expected ok=%0b code=%0d chars=%0d, got ok=%0b code=%0d chars=%0d",
            verdicts_checked, want.ok, want.code, want.chars,
            out_valid_res, out_error_code, out_char_count));
      end
    end
  end

  // receiver stall pattern, with an occasional long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_ticket) begin
      hold_seen <= hold_ticket;
      hold_left <= HOLD_CYCLES - 1;
      held_cycles <= held_cycles + 1;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      held_cycles <= held_cycles + 1;
      out_stall <= 1'b1;
    end else begin
      stall_phase <= (stall_phase + 1) % 5;
      case (stall_mode)
        STALL_LIGHT:    out_stall <= $urandom_range(0, 3) == 0;
        STALL_HEAVY:    out_stall <= $urandom_range(0, 9) < 7;
        STALL_PERIODIC: out_stall <= stall_phase < 3;
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  task automatic send_item(input logic [7:0] b, input logic has, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_has_byte <= has;
    in_last <= fin;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_password(input bit sprinkle);
    int i;
    bit tail_close;
    tail_close = pw_buf.size() == 0 || (sprinkle && $urandom_range(0, 6) == 0);
    for (i = 0; i < pw_buf.size(); i++) begin
      if (sprinkle && $urandom_range(0, 19) == 0)
        send_item(8'($urandom), 1'b0, 1'b0);
      send_item(pw_buf[i], 1'b1, !tail_close && i == pw_buf.size() - 1);
    end
    if (tail_close)
      send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  task automatic set_limits(input logic [9:0] mb, input logic [9:0] mn, input logic [9:0] mx);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_MAX_BYTES;
    cfg_data <= mb;
    @(posedge clk);
    cfg_index <= CFG_MIN_CHARS;
    cfg_data <= mn;
    @(posedge clk);
    cfg_index <= CFG_MAX_CHARS;
    cfg_data <= mx;
    @(posedge clk);
    // unused index must leave all limits alone
    cfg_index <= CFG_UNUSED;
    cfg_data <= 10'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_max_bytes = mb;
    lim_min_chars = mn;
    lim_max_chars = mx;
    limit_writes++;
  endtask

  // Mostly well-formed text; a quarter gets one defect, a tenth is raw noise.
  task automatic make_random_password(input int len_hi);
    int pick, n, pos;
    logic [20:0] cp;
    byte_q_t bad;
    pw_buf.delete();
    bad.delete();
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      n = $urandom_range(1, 10);
      repeat (n) pw_buf.push_back(8'($urandom));
    end else begin
      n = $urandom_range(0, len_hi);
      repeat (n) begin
        case ($urandom_range(0, 5))
          3: begin
            cp = 21'($urandom_range(21'hA0, 21'h7FF));
            pw_buf.push_back({3'b110, cp[10:6]});
            pw_buf.push_back({2'b10, cp[5:0]});
          end
          4: begin
            do cp = 21'($urandom_range(CP_MIN_3B, 21'hFFFF));
            while (cp >= CP_SURR_LO && cp <= CP_SURR_HI);
            pw_buf.push_back({4'b1110, cp[15:12]});
            pw_buf.push_back({2'b10, cp[11:6]});
            pw_buf.push_back({2'b10, cp[5:0]});
          end
          5: begin
            cp = 21'($urandom_range(CP_MIN_4B, CP_MAX));
            pw_buf.push_back({5'b11110, cp[20:18]});
            pw_buf.push_back({2'b10, cp[17:12]});
            pw_buf.push_back({2'b10, cp[11:6]});
            pw_buf.push_back({2'b10, cp[5:0]});
          end
          default: pw_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
        endcase
      end
      if (pick >= 75) begin
        pos = $urandom_range(0, pw_buf.size());
        case ($urandom_range(0, 9))
          0: bad = '{8'hE0, 8'($urandom_range(8'h80, 8'h9F)), 8'($urandom_range(8'h80, 8'hBF))};
          1: bad = '{8'hED, 8'($urandom_range(8'hA0, 8'hBF)), 8'($urandom_range(8'h80, 8'hBF))};
          2: bad = '{8'hF4, 8'($urandom_range(8'h90, 8'hBF)), 8'h80, 8'($urandom_range(8'h80, 8'hBF))};
          3: bad = '{8'hF0, 8'($urandom_range(8'h80, 8'h8F)), 8'hBF, 8'($urandom_range(8'h80, 8'hBF))};
          4: bad = '{8'hC2, 8'($urandom_range(8'h80, 8'h9F))};
          5: bad = '{$urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hC1))
                                         : 8'($urandom_range(8'hF5, 8'hFF))};
          6: bad = '{$urandom_range(0, 3) == 0 ? ASCII_DEL : 8'($urandom_range(0, 8'h1F))};
          7: if (pw_buf.size() != 0) pw_buf[$urandom_range(0, pw_buf.size() - 1)] = 8'($urandom);
          8: if (pw_buf.size() != 0) void'(pw_buf.pop_back());
          default: pw_buf.push_back(8'($urandom_range(8'hC2, 8'hF4)));
        endcase
        foreach (bad[i]) pw_buf.insert(pos + i, bad[i]);
      end
    end
  endtask

  task automatic test_decode_errors();
    set_limits(10'd64, 10'd1, 10'd10);
    gap_max = 2;
    stall_mode <= STALL_LIGHT;
    pw_buf = '{8'h20, 8'h7E};             send_password(1'b0);
    pw_buf = '{8'h00};                    send_password(1'b0);
    pw_buf = '{8'h7F};                    send_password(1'b0);
    pw_buf = '{8'h80};                    send_password(1'b0);
    pw_buf = '{8'hC1};                    send_password(1'b0);
    pw_buf = '{8'hFF};                    send_password(1'b0);
    pw_buf = '{8'hC2, 8'h80};             send_password(1'b0);
    pw_buf = '{8'hE0, 8'h9F, 8'hBF};      send_password(1'b0);
    pw_buf = '{8'hED, 8'hA0, 8'h80};      send_password(1'b0);
    pw_buf = '{8'hF4, 8'h90, 8'h80, 8'h80}; send_password(1'b0);
    pw_buf = '{8'hC3, 8'h41};             send_password(1'b0);
    // open sequence at the end reports truncated even with a broken continuation
    pw_buf = '{8'hE2, 8'h41};             send_password(1'b0);
    // an item without a byte that does not close anything, then an empty password
    send_item(8'hFF, 1'b0, 1'b0);
    pw_buf.delete();                      send_password(1'b0);
  endtask

  task automatic test_length_limits();
    set_limits(10'd4, 10'd2, 10'd3);
    gap_max = 0;
    stall_mode <= STALL_PERIODIC;
    pw_buf = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};        send_password(1'b0);
    pw_buf = '{8'h41, 8'h42, 8'h43, 8'h44};        send_password(1'b0);
    // byte limit wins over an earlier control byte
    pw_buf = '{8'h00, 8'h41, 8'h42, 8'h43, 8'h44}; send_password(1'b0);
    pw_buf = '{8'h41, 8'h42, 8'hF0, 8'h9F};        send_password(1'b0);
  endtask

  // byte and character counters both run into their ceilings
  task automatic test_counter_saturation();
    int i;
    set_limits(10'd1023, 10'd0, 10'd1023);
    gap_max = 1;
    stall_mode <= STALL_HEAVY;
    for (i = 0; i < 1030; i++)
      send_item(8'($urandom_range(8'h21, 8'h7E)), 1'b1, i == 1029);
  endtask

  task automatic test_input_backpressure();
    set_limits(10'd8, 10'd1, 10'd4);
    gap_max = 0;
    stall_mode <= STALL_NONE;
    hold_ticket <= hold_ticket + 1;
    repeat (40) begin
      pw_buf = '{8'($urandom_range(8'h20, 8'h7E))};
      send_password(1'b0);
    end
  endtask

  task automatic run_phase(input logic [9:0] mb, input logic [9:0] mn, input logic [9:0] mx,
                           input int len_hi, input int gaps, input int stalls);
    int first_byte;
    set_limits(mb, mn, mx);
    gap_max = gaps;
    stall_mode <= stalls;
    first_byte = n_bytes_sent;
    while (n_bytes_sent - first_byte < 30) begin
      make_random_password(len_hi);
      send_password(1'b1);
    end
  endtask

  task automatic test_random_passwords();
    run_phase(MAX_BYTES_RST, MIN_CHARS_RST, MAX_CHARS_RST, 70, 3, STALL_LIGHT);
    run_phase(10'd40, 10'd3, 10'd12, 14, 0, STALL_NONE);
    run_phase(10'd1023, 10'd1023, 10'd0, 10, 6, STALL_HEAVY);
    run_phase(10'($urandom), 10'($urandom_range(0, 6)), 10'($urandom_range(0, 20)),
              20, 2, STALL_PERIODIC);
    run_phase(10'd0, 10'd0, 10'd0, 5, 4, STALL_LIGHT);
    run_phase(10'd30, 10'd0, 10'd1023, 12, 1, STALL_HEAVY);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_decode_errors();
    test_length_limits();
    test_counter_saturation();
    test_input_backpressure();
    test_random_passwords();
    wait_idle();
    repeat (LATENCY_PAD) @(posedge clk);
    if (pending_verdicts.size() != 0)
      note_failure($sformatf("%0d verdicts never arrived", pending_verdicts.size()));
    $display("%0d passwords from %0d bytes and %0d byteless items, %0d verdicts checked",
             n_passwords, n_bytes_sent, n_empty, verdicts_checked);
    $display("%0d limit settings, input stalled on %0d offers, receiver held off %0d cycles",
             limit_writes, stalled_offers, held_cycles);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
